### hdl/running_mean_motion_compositor_top_defines.svh
// Assertion macros for the running mean motion compositor.
// No dependencies; included by the RTL files that assert.
`ifndef RUNNING_MEAN_MOTION_COMPOSITOR_TOP_DEFINES_SVH
`define RUNNING_MEAN_MOTION_COMPOSITOR_TOP_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define RMMC_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rmmc assertion failed");

// Next-cycle implication, checked out of reset.
`define RMMC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rmmc assertion failed");

`endif

### hdl/rmmc_pkg.sv
// Package for the running mean motion compositor: frame geometry, widths,
// item and pipeline stage types. No dependencies.
`default_nettype none

package rmmc_pkg;

  localparam int FRAME_WIDTH  = 640;
  localparam int FRAME_HEIGHT = 480;
  localparam int COUNT_BITS   = 16;

  localparam int CHANNELS = 3;
  localparam int SMP_W    = 8;
  localparam int MEAN_W   = 2 * SMP_W;               // 8.8 fixed point
  localparam int PIX      = FRAME_WIDTH * FRAME_HEIGHT;
  localparam int ADDR_W   = (PIX > 1) ? $clog2(PIX) : 1;
  localparam int NUM_W    = MEAN_W + COUNT_BITS + 1;  // mean*n + sample*256
  localparam int NSTG     = 2 + MEAN_W;               // read, multiply, divide bits

  localparam logic [COUNT_BITS-1:0] COUNT_MAX    = '1;
  localparam logic [SMP_W-1:0]      THRESH_RESET = SMP_W'(90);
  localparam logic [SMP_W-1:0]      WHITE        = SMP_W'(255);

  typedef logic [CHANNELS-1:0][SMP_W-1:0]  pix_t;
  typedef logic [CHANNELS-1:0][MEAN_W-1:0] mean_vec_t;

  typedef struct packed {
    logic [9:0] column;
    logic [8:0] row;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       frame_end;
  } in_item_t;

  typedef struct packed {
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
    logic       moving;
  } out_item_t;

  typedef struct packed {
    logic                                in_frame;
    logic [ADDR_W-1:0]                   addr;
    pix_t                                smp;
    logic [COUNT_BITS-1:0]               n;
    pix_t                                held;
    logic [CHANNELS-1:0][NUM_W-1:0]      rem;
    mean_vec_t                           quo;
  } stg_t;

endpackage

`default_nettype wire

### hdl/running_mean_motion_compositor_top.sv
// Running mean motion compositor top level: mean and held-image memories,
// multiply and pipelined divide, still test. Depends on rmmc_pkg and the
// assertion macro header.
//
// One pixel item per clock is accepted while in_stall is low, and every item yields
// one result item after its memory read at acceptance, the 16x16 multiply, one
// divider stage per quotient bit of the 8.8 mean, then the still test into the
// output register.
// A pixel whose address is still inside that pipeline stalls the input until
// the earlier item has written back, so a normal raster stream runs at one
// item per clock while out_stall is low. After reset the held image is cleared
// to white one pixel a cycle, during which in_stall is high; the threshold
// register can be written at any time (cfg_ready is 1).
`default_nettype none

`include "running_mean_motion_compositor_top_defines.svh"

module running_mean_motion_compositor_top (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  in_valid,
  output logic                 in_stall,
  input  rmmc_pkg::in_item_t   in_data,
  output logic                 out_valid,
  input  wire                  out_stall,
  output rmmc_pkg::out_item_t  out_data,
  input  wire                  cfg_valid,
  output logic                 cfg_ready,
  input  wire  [7:0]           cfg_data
);
  import rmmc_pkg::*;

  logic [SMP_W-1:0]      threshold_r;
  logic [COUNT_BITS-1:0] frame_count_r;
  logic                  clr_r;
  logic [ADDR_W-1:0]     clr_addr_r;

  stg_t              stg_r   [NSTG];
  stg_t              stg_nxt [NSTG];
  logic [NSTG-1:0]   vld_r;

  mean_vec_t         means_mem [PIX];
  pix_t              held_mem  [PIX];
  mean_vec_t         means_q_r;
  pix_t              held_q_r;

  out_item_t         out_r;
  logic              out_valid_r;

  logic              adv;
  logic              accept;
  logic              in_frame_w;
  logic [ADDR_W-1:0] in_addr;
  logic              hazard;
  pix_t              live_w;
  logic              moving_w;
  logic [CHANNELS-1:0] still_w;
  logic              wr_pix;

  assign live_w = {in_data.blue, in_data.green, in_data.red};

  assign in_frame_w = (32'(in_data.column) < FRAME_WIDTH) &&
                      (32'(in_data.row) < FRAME_HEIGHT);
  assign in_addr = ADDR_W'(32'(in_data.row) * FRAME_WIDTH + 32'(in_data.column));

  always_comb begin
    hazard = 1'b0;
    for (int k = 0; k < NSTG; k++) begin
      if (vld_r[k] && stg_r[k].in_frame && (stg_r[k].addr == in_addr)) begin
        hazard = 1'b1;
      end
    end
  end

  assign adv       = !out_valid_r || !out_stall;
  assign in_stall  = clr_r || !adv || (in_frame_w && hazard);
  assign accept    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // Pipeline next values
  always_comb begin
    logic [MEAN_W-1:0]   mean_v;
    logic [NUM_W-1:0]    dsh;
    logic [COUNT_BITS:0] dvs;
    for (int k = 0; k < NSTG; k++) begin
      stg_nxt[k] = stg_r[k];
    end
    stg_nxt[0].in_frame = in_frame_w;
    stg_nxt[0].addr     = in_addr;
    stg_nxt[0].smp      = live_w;
    stg_nxt[0].n        = frame_count_r;

    // multiply stage; a never-written mean is not used on the first frame
    stg_nxt[1]      = stg_r[0];
    stg_nxt[1].held = held_q_r;
    stg_nxt[1].quo  = '0;
    for (int c = 0; c < CHANNELS; c++) begin
      mean_v = (stg_r[0].n == '0) ? '0 : means_q_r[c];
      stg_nxt[1].rem[c] = NUM_W'(mean_v * stg_r[0].n) +
                          NUM_W'({stg_r[0].smp[c], SMP_W'(0)});
    end

    // restoring divide by n+1, one quotient bit per stage
    for (int k = 2; k < NSTG; k++) begin
      stg_nxt[k] = stg_r[k-1];
      dvs = {1'b0, stg_r[k-1].n} + (COUNT_BITS+1)'(1);
      dsh = NUM_W'(dvs) << (MEAN_W - 1 - (k - 2));
      for (int c = 0; c < CHANNELS; c++) begin
        if (stg_r[k-1].rem[c] >= dsh) begin
          stg_nxt[k].rem[c] = stg_r[k-1].rem[c] - dsh;
          stg_nxt[k].quo[c][MEAN_W - 1 - (k - 2)] = 1'b1;
        end
      end
    end
  end

  // still test on the updated mean
  always_comb begin
    logic [MEAN_W-1:0] s256;
    logic [MEAN_W-1:0] ad;
    for (int c = 0; c < CHANNELS; c++) begin
      s256 = {stg_r[NSTG-1].smp[c], SMP_W'(0)};
      ad   = (s256 >= stg_r[NSTG-1].quo[c]) ? s256 - stg_r[NSTG-1].quo[c]
                                              : stg_r[NSTG-1].quo[c] - s256;
      still_w[c] = ad < {threshold_r, SMP_W'(0)};
    end
    moving_w = !stg_r[NSTG-1].in_frame || !(&still_w);
  end

  assign wr_pix = adv && vld_r[NSTG-1] && stg_r[NSTG-1].in_frame;

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      threshold_r   <= THRESH_RESET;
      frame_count_r <= '0;
      clr_r         <= 1'b1;
      clr_addr_r    <= '0;
      vld_r         <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_valid) begin
        threshold_r <= cfg_data;
      end
      if (accept && in_data.frame_end && (frame_count_r != COUNT_MAX)) begin
        frame_count_r <= frame_count_r + COUNT_BITS'(1);
      end
      if (clr_r) begin
        if (clr_addr_r == ADDR_W'(PIX - 1)) begin
          clr_r <= 1'b0;
        end else begin
          clr_addr_r <= clr_addr_r + ADDR_W'(1);
        end
      end
      if (adv) begin
        vld_r       <= {vld_r[NSTG-2:0], accept};
        out_valid_r <= vld_r[NSTG-1];
      end
    end
  end

  // pipeline payload and output register
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < NSTG; k++) begin
        stg_r[k] <= stg_nxt[k];
      end
      out_r.moving <= moving_w;
      if (moving_w) begin
        out_r.red_out   <= stg_r[NSTG-1].smp[0];
        out_r.green_out <= stg_r[NSTG-1].smp[1];
        out_r.blue_out  <= stg_r[NSTG-1].smp[2];
      end else begin
        out_r.red_out   <= stg_r[NSTG-1].held[0];
        out_r.green_out <= stg_r[NSTG-1].held[1];
        out_r.blue_out  <= stg_r[NSTG-1].held[2];
      end
    end
  end

  // memories: read at item entry, write back at pipeline exit
  always_ff @(posedge clk) begin
    if (adv) begin
      means_q_r <= means_mem[in_addr];
    end
    if (wr_pix) begin
      means_mem[stg_r[NSTG-1].addr] <= stg_r[NSTG-1].quo;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      held_q_r <= held_mem[in_addr];
    end
    if (clr_r) begin
      held_mem[clr_addr_r] <= {CHANNELS{WHITE}};
    end else if (wr_pix && moving_w) begin
      held_mem[stg_r[NSTG-1].addr] <= stg_r[NSTG-1].smp;
    end
  end

  `RMMC_ASSERT_NOW(a_no_accept_in_clear, clr_r, in_stall)
  `RMMC_ASSERT_NEXT(a_count_saturates, frame_count_r == COUNT_MAX, frame_count_r == COUNT_MAX)
  `RMMC_ASSERT_NOW(a_clear_full_sweep, $fell(clr_r), $past(clr_addr_r) == ADDR_W'(PIX - 1))
  `RMMC_ASSERT_NOW(a_no_write_in_clear, clr_r, !vld_r[NSTG-1])

endmodule

`default_nettype wire

### dv/tb_running_mean_motion_compositor_top.sv
// Self-checking testbench for running_mean_motion_compositor_top: directed table, then
// random pixel streams over several thresholds.
// Depends on rmmc_pkg and the RTL top level.
`default_nettype none

module tb_running_mean_motion_compositor_top;
  import rmmc_pkg::*;

  typedef struct {
    in_item_t  px;
    bit        known;
    out_item_t res;
  } dir_row_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  in_item_t   in_data = '0;
  logic       in_stall;
  logic       out_valid;
  logic       out_stall = 1'b0;
  out_item_t  out_data;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [7:0] cfg_data = '0;

  // shadow of the block state
  mean_vec_t             mean_mem [int];
  pix_t                  held_mem [int];
  int                    primed_px[$];
  logic [COUNT_BITS-1:0] frame_cnt = '0;
  logic [7:0]            still_thr = THRESH_RESET;

  out_item_t pending_q[$];
  int        n_mismatch = 0;
  int        n_moving = 0;
  int        n_held = 0;
  int        n_items = 0;
  int        burst_left = 0;
  bit        hold_req = 1'b0;
  bit        hold_seen = 1'b0;

  dir_row_t dir_tbl[$];

  running_mean_motion_compositor_top dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  initial begin
    #40000000;
    $display("timeout with %0d items pending", pending_q.size());
    $display("FAIL");
    $finish;
  end

  // Updates the shadow means and held image, returns the composited pixel.
  function automatic out_item_t composite_pixel(in_item_t it);
    int          idx;
    mean_vec_t   m;
    pix_t        s;
    pix_t        h;
    logic [63:0] num;
    logic [63:0] diff;
    bit          still;
    out_item_t   r;
    s = {it.red, it.green, it.blue};
    r = {it.red, it.green, it.blue, 1'b1};
    if (it.column < FRAME_WIDTH && it.row < FRAME_HEIGHT) begin
      idx = int'(it.row) * FRAME_WIDTH + int'(it.column);
      m = mean_mem.exists(idx) ? mean_mem[idx] : '0;
      h = held_mem.exists(idx) ? held_mem[idx] : {CHANNELS{WHITE}};
      if (!mean_mem.exists(idx)) primed_px = {primed_px, idx};
      still = 1'b1;
      for (int c = 0; c < CHANNELS; c++) begin
        num  = 64'(m[c]) * 64'(frame_cnt) + (64'(s[c]) << 8);
        m[c] = 16'(num / (64'(frame_cnt) + 64'd1));
        diff = ((64'(s[c]) << 8) >= 64'(m[c])) ? (64'(s[c]) << 8) - 64'(m[c])
                                                : 64'(m[c]) - (64'(s[c]) << 8);
        if (!(diff < (64'(still_thr) << 8))) still = 1'b0;
      end
      mean_mem[idx] = m;
      if (still) r = {h[2], h[1], h[0], 1'b0};
      else held_mem[idx] = s;
    end
    if (it.frame_end && frame_cnt != COUNT_MAX) frame_cnt++;
    return r;
  endfunction

  // Prediction without touching the shadow state.
  function automatic out_item_t composite_pixel_peek(in_item_t it);
    mean_vec_t             m_save [int];
    pix_t                  h_save [int];
    int                    p_save [$];
    logic [COUNT_BITS-1:0] c_save;
    out_item_t             r;
    m_save = mean_mem; h_save = held_mem; p_save = primed_px; c_save = frame_cnt;
    r = composite_pixel(it);
    mean_mem = m_save; held_mem = h_save; primed_px = p_save; frame_cnt = c_save;
    return r;
  endfunction

  // Offers one item, waits for acceptance, then maybe leaves a gap.
  task automatic send_pixel(in_item_t it);
    out_item_t r;
    int        gap;
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall);
    r = composite_pixel(it);
    pending_q = {pending_q, r};
    n_items++;
    if (r.moving) n_moving++; else n_held++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
    end
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (25) @(posedge clk);
  endtask

  task automatic write_thr(logic [7:0] v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    still_thr = v;
    cfg_valid <= 1'b0;
  endtask

  function automatic in_item_t off_frame_pixel(bit fe);
    in_item_t it;
    it = {10'($urandom), 9'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), fe};
    if ($urandom_range(0, 1)) it.column = 10'($urandom_range(FRAME_WIDTH, 1023));
    else it.row = 9'($urandom_range(FRAME_HEIGHT, 511));
    return it;
  endfunction

  function automatic logic [7:0] near_sample(logic [15:0] mean);
    int v;
    v = int'(mean[15:8]) + $urandom_range(0, 2 * still_thr + 2) - still_thr - 1;
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return 8'(v);
  endfunction

  // Well-formed item: an off-frame pixel or a pixel already primed, mostly near its mean.
  function automatic in_item_t stream_pixel();
    in_item_t  it;
    int        idx;
    mean_vec_t m;
    it.frame_end = ($urandom_range(0, 9) == 0);
    if ($urandom_range(0, 9) == 0) return off_frame_pixel(it.frame_end);
    idx = primed_px[$urandom_range(0, primed_px.size() - 1)];
    m = mean_mem[idx];
    it.column = 10'(idx % FRAME_WIDTH);
    it.row    = 9'(idx / FRAME_WIDTH);
    if ($urandom_range(0, 3) == 0) begin
      it.red = 8'($urandom); it.green = 8'($urandom); it.blue = 8'($urandom);
    end else begin
      it.red = near_sample(m[2]); it.green = near_sample(m[1]);
      it.blue = near_sample(m[0]);
    end
    return it;
  endfunction

  function automatic void add_row(in_item_t px, bit known, out_item_t res);
    dir_row_t d;
    d.px = px; d.known = known; d.res = res;
    dir_tbl = {dir_tbl, d};
  endfunction

  // Result checker and receiver stall pattern.
  initial begin
    out_item_t exp_r;
    int        free_run;
    int        stall_run;
    int        hold_left;
    free_run = 0; stall_run = 0; hold_left = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) begin
        if (pending_q.size() == 0) begin
          n_mismatch++;
          if (n_mismatch <= 10) $display("unexpected result item %h", out_data);
        end else begin
          exp_r = pending_q.pop_front();
          if (out_data !== exp_r) begin
            n_mismatch++;
            if (n_mismatch <= 10)
              $display("mismatch: exp rgb %0d %0d %0d mv %0b, got %0d %0d %0d mv %0b",
                       exp_r.red_out, exp_r.green_out, exp_r.blue_out, exp_r.moving,
                       out_data.red_out, out_data.green_out, out_data.blue_out,
                       out_data.moving);
          end
        end
      end
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = 300;
        hold_seen = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (stall_run > 0) begin
        stall_run--;
        out_stall <= 1'b1;
      end else if (free_run > 0) begin
        free_run--;
        out_stall <= 1'b0;
      end else begin
        free_run  = $urandom_range(0, 40);
        stall_run = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
        out_stall <= 1'b0;
      end
    end
  end

  initial begin
    logic [7:0] thr_list[$];
    in_item_t   it;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    write_thr(THRESH_RESET);

    // first frame: every mean equals its sample, so every in-frame pixel is still
    for (int i = 0; i < 16; i++) begin
      it = {10'($urandom_range(0, FRAME_WIDTH - 1)), 9'($urandom_range(0, FRAME_HEIGHT - 1)),
            8'($urandom), 8'($urandom), 8'($urandom), 1'b0};
      send_pixel(it);
    end

    add_row({10'd0,   9'd0,   8'd10,  8'd20,  8'd30,  1'b0}, 1, {8'd255, 8'd255, 8'd255, 1'b0});
    add_row({10'd639, 9'd479, 8'd255, 8'd255, 8'd255, 1'b0}, 1, {8'd255, 8'd255, 8'd255, 1'b0});
    add_row({10'd639, 9'd0,   8'd0,   8'd0,   8'd0,   1'b0}, 1, {8'd255, 8'd255, 8'd255, 1'b0});
    add_row({10'd0,   9'd479, 8'd128, 8'd64,  8'd200, 1'b0}, 1, {8'd255, 8'd255, 8'd255, 1'b0});
    add_row({10'd1023, 9'd511, 8'd1,  8'd2,   8'd3,   1'b0}, 1, {8'd1, 8'd2, 8'd3, 1'b1});
    add_row({10'd640, 9'd0,   8'd0,   8'd255, 8'd0,   1'b0}, 1, {8'd0, 8'd255, 8'd0, 1'b1});
    add_row({10'd0,   9'd480, 8'd255, 8'd0,   8'd255, 1'b0}, 1, {8'd255, 8'd0, 8'd255, 1'b1});
    add_row({10'd700, 9'd500, 8'd7,   8'd8,   8'd9,   1'b1}, 1, {8'd7, 8'd8, 8'd9, 1'b1});
    add_row({10'd0,   9'd0,   8'd10,  8'd20,  8'd30,  1'b0}, 0, '0);
    add_row({10'd0,   9'd0,   8'd255, 8'd255, 8'd255, 1'b0}, 0, '0);
    add_row({10'd0,   9'd0,   8'd0,   8'd0,   8'd0,   1'b0}, 0, '0);
    add_row({10'd639, 9'd479, 8'd250, 8'd250, 8'd250, 1'b1}, 0, '0);
    add_row({10'd639, 9'd0,   8'd89,  8'd0,   8'd0,   1'b0}, 0, '0);
    add_row({10'd639, 9'd0,   8'd0,   8'd90,  8'd0,   1'b0}, 0, '0);
    foreach (dir_tbl[i]) begin
      // known rows: the checker compares against the predictor, which must agree
      if (dir_tbl[i].known && composite_pixel_peek(dir_tbl[i].px) !== dir_tbl[i].res) begin
        n_mismatch++;
        if (n_mismatch <= 10) $display("directed row %0d: table and prediction disagree", i);
      end
      send_pixel(dir_tbl[i].px);
    end
    drain();

    thr_list = '{8'd0, 8'd255, 8'd1, 8'(THRESH_RESET), 8'($urandom_range(2, 254)), 8'd37};
    foreach (thr_list[p]) begin
      write_thr(thr_list[p]);
      for (int i = 0; i < 110; i++) begin
        if (p == 1 && i == 20) hold_req = 1'b1;
        send_pixel(stream_pixel());
      end
      drain();
    end

    for (int i = 0; i < 40; i++) send_pixel(stream_pixel());
    drain();

    $display("%0d items over %0d thresholds (%0d moving, %0d held), long output hold %0b",
             n_items, thr_list.size() + 1, n_moving, n_held, hold_seen);
    if (n_mismatch == 0 && pending_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("%0d mismatches", n_mismatch);
      $display("FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
